>>> design/tcw_pkg.sv
package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Item modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Character and colour codes
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CODE   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'h0F;
  localparam int         NIBBLE_W     = 4;
  localparam int         CELL_W       = 16;

  // Configuration port
  localparam int         CFG_AW = 1;
  localparam int         CFG_DW = NIBBLE_W;
  localparam logic [CFG_AW-1:0] CFG_FG = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_BG = 1'd1;

  // Result item, cell_char in the lowest bits
  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_color;
    logic [7:0] cell_char;
  } tcw_result_t;

endpackage

>>> design/text_console_writer.sv
// Text-mode console writer. The screen (ROWS x COLUMNS cells, each a character
// byte with a colour byte above it) lives in one block RAM with a registered
// read port; a cursor sits in registers. tuser carries the mode: 0 puts
// char_code at the cursor (10 is newline), 1 reads the cell at read_row and
// read_col, 2 clears the screen in the current colour. Every item gives one
// result with the cell read (zero unless mode 1 in range) and the cursor.
// A newline, or a character that wraps, on the last row scrolls: the block
// walks the RAM one cell a cycle, copying every row up one and then blanking
// the last row, and a wrapped character goes down after it. A clear also
// walks every cell. A finished result waits for a free output register, so
// the block can hold while m_axis_tready is low.
// After reset the block fills the RAM with white-on-black spaces and takes
// no item until then. The user writes the colour registers through cfg_we_i
// only while the block is idle; the block itself does not enforce it.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,  // char_code, read_row, read_col
  input  logic [1:0]                 s_axis_tuser,  // mode
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // cell_char, cell_color,
                                                    // cursor_row, cursor_col
  input  logic                       cfg_we_i,
  input  logic [tcw_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [tcw_pkg::CFG_DW-1:0] cfg_data_i
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [NIBBLE_W-1:0] fg_q, fg_d;
  logic [NIBBLE_W-1:0] bg_q, bg_d;
  tcw_result_t         res;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [CELL_W-1:0]   mem_rdata;

  // Colour registers
  always_comb begin
    fg_d = fg_q;
    bg_d = bg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FG:  fg_d = cfg_data_i;
        CFG_BG:  bg_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= RESET_COLOR[NIBBLE_W-1:0];
      bg_q <= RESET_COLOR[2*NIBBLE_W-1:NIBBLE_W];
    end else begin
      fg_q <= fg_d;
      bg_q <= bg_d;
    end
  end

  tcw_ctl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_char_i   (s_axis_tdata[7:0]),
    .in_row_i    (s_axis_tdata[12:8]),
    .in_col_i    (s_axis_tdata[19:13]),
    .color_i     ({bg_q, fg_q}),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tcw_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata = {4'd0, res};

endmodule

>>> design/tcw_mem.sv
module tcw_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [tcw_pkg::CELL_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [tcw_pkg::CELL_W-1:0] rdata_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/tcw_ctl.sv
module tcw_ctl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int AW      = 11
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 in_mode_i,
  input  logic [7:0]                 in_char_i,
  input  logic [4:0]                 in_row_i,
  input  logic [6:0]                 in_col_i,
  input  logic [7:0]                 color_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tcw_pkg::tcw_result_t       out_res_o,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0] mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  logic [tcw_pkg::CELL_W-1:0] mem_rdata_i
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IW    = $clog2(CELLS + 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_WRITE  = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_BLANK  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] base_q, base_d;     // row_q * COLUMNS, kept incrementally
  logic [IW-1:0] idx_q, idx_d;       // sweep pointer
  logic          cp_v_q, cp_v_d;     // scroll read in flight
  logic [AW-1:0] cp_dst_q, cp_dst_d;
  logic          pend_wr_q, pend_wr_d;
  logic [7:0]    char_q, char_d;
  logic          rd_ok_q, rd_ok_d;
  logic          out_valid_q, out_valid_d;
  tcw_result_t   out_res_q, out_res_d;

  logic          last_row;
  logic          col_full;
  logic          rd_in_range;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] cur_addr;
  logic          out_free;

  assign last_row    = (32'(row_q) + 32'd1) >= ROWS;
  assign col_full    = 32'(col_q) >= COLUMNS;
  assign rd_in_range = (32'(in_row_i) < ROWS) && (32'(in_col_i) < COLUMNS);
  assign rd_addr     = AW'(32'(in_row_i) * COLUMNS + 32'(in_col_i));
  assign cur_addr    = AW'(base_q + AW'(col_q));
  assign out_free    = !out_valid_q || out_ready_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    base_d      = base_q;
    idx_d       = idx_q;
    cp_v_d      = cp_v_q;
    cp_dst_d    = cp_dst_q;
    pend_wr_d   = pend_wr_q;
    char_d      = char_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // Fill the screen with white-on-black spaces after reset
      S_INIT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[AW-1:0];
        mem_wdata_o = {RESET_COLOR, BLANK_CODE};
        idx_d       = idx_q + IW'(1);
        if (idx_q == IW'(CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          char_d    = in_char_i;
          rd_ok_d   = 1'b0;
          pend_wr_d = 1'b0;
          state_d   = S_DONE;
          case (in_mode_i)
            MODE_PUT: begin
              if (in_char_i == NEWLINE_CODE || col_full) begin
                // newline, or wrap before the character goes down
                pend_wr_d = (in_char_i != NEWLINE_CODE);
                col_d     = '0;
                if (!last_row) begin
                  row_d   = row_q + RW'(1);
                  base_d  = base_q + AW'(COLUMNS);
                  state_d = (in_char_i != NEWLINE_CODE) ? S_WRITE : S_DONE;
                end else if (ROWS > 1) begin
                  idx_d   = IW'(COLUMNS);
                  cp_v_d  = 1'b0;
                  state_d = S_SCROLL;
                end else begin
                  idx_d   = '0;
                  state_d = S_BLANK;
                end
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = cur_addr;
                mem_wdata_o = {color_i, in_char_i};
                col_d       = col_q + CW'(1);
              end
            end
            MODE_READ: begin
              if (rd_in_range) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = rd_addr;
                rd_ok_d     = 1'b1;
              end
            end
            MODE_CLEAR: begin
              idx_d   = '0;
              state_d = S_BLANK;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Character after a wrap
      S_WRITE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cur_addr;
        mem_wdata_o = {color_i, char_q};
        col_d       = col_q + CW'(1);
        state_d     = S_DONE;
      end

      // Copy every cell up one row: read one cell, write the previous one
      S_SCROLL: begin
        mem_re_o    = idx_q < IW'(CELLS);
        mem_raddr_o = idx_q[AW-1:0];
        mem_we_o    = cp_v_q;
        mem_waddr_o = cp_dst_q;
        mem_wdata_o = mem_rdata_i;
        cp_v_d      = mem_re_o;
        cp_dst_d    = AW'(idx_q - IW'(COLUMNS));
        idx_d       = idx_q + IW'(1);
        if (!mem_re_o) begin
          idx_d   = IW'(CELLS - COLUMNS);
          state_d = S_BLANK;
        end
      end

      // Blank from idx_q to the end of the screen in the current colour
      S_BLANK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[AW-1:0];
        mem_wdata_o = {color_i, BLANK_CODE};
        idx_d       = idx_q + IW'(1);
        if (idx_q == IW'(CELLS - 1)) begin
          state_d = pend_wr_q ? S_WRITE : S_DONE;
        end
      end

      // Hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_res_d.cell_char  = rd_ok_q ? mem_rdata_i[7:0]  : 8'd0;
          out_res_d.cell_color = rd_ok_q ? mem_rdata_i[15:8] : 8'd0;
          out_res_d.cursor_row = 5'(row_q);
          out_res_d.cursor_col = 7'(col_q);
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      idx_q       <= '0;
      cp_v_q      <= 1'b0;
      pend_wr_q   <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      base_q      <= base_d;
      idx_q       <= idx_d;
      cp_v_q      <= cp_v_d;
      pend_wr_q   <= pend_wr_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cp_dst_q  <= cp_dst_d;
    char_q    <= char_d;
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

>>> bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int ROWS = ROWS_DEF;
  localparam int CELLS = ROWS * COLS;
  // a scroll or a clear walks every cell; reset fills the RAM first
  localparam int WALK_CYCLES = CELLS + 16;
  localparam int IDLE_LIMIT = 5 * CELLS;
  localparam int PHASE_ITEMS = 250;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // char_code, read_row, read_col
  logic [1:0]  s_axis_tuser;   // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // cell_char, cell_color, cursor_row, cursor_col
  logic        cfg_we_i;
  logic [CFG_AW-1:0] cfg_addr_i;
  logic [CFG_DW-1:0] cfg_data_i;

  text_console_writer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Console shadow: screen, cursor, colors
  logic [15:0] screen_shadow [CELLS];
  int unsigned cur_row, cur_col;
  logic [3:0]  fg_color, bg_color;

  tcw_result_t pending_results [$];

  int n_items, n_puts, n_reads, n_clears, n_scrolls, n_wraps;
  int n_settings, n_checked, n_fail;
  int burst_left;
  int idle_cycles;
  int stall_pct;
  int rx_cycle;

  // Directed stimulus; expected result typed in where it is obvious
  typedef struct {
    logic [1:0] mode;
    logic [7:0] ch;
    logic [4:0] rr;
    logic [6:0] rc;
    bit         typed;
    logic [7:0] e_char;
    logic [7:0] e_color;
    logic [4:0] e_row;
    logic [6:0] e_col;
  } stim_row_t;

  stim_row_t directed_rows [19];

  always #1 clk_i = ~clk_i;

  // Cursor to the start of the next row, scrolling on the last one
  function automatic void next_line();
    int i;
    cur_col = 0;
    if (cur_row + 1 < ROWS) begin
      cur_row++;
    end else begin
      for (i = COLS; i < CELLS; i++) screen_shadow[i - COLS] = screen_shadow[i];
      for (i = (ROWS - 1) * COLS; i < CELLS; i++)
        screen_shadow[i] = {bg_color, fg_color, BLANK_CODE};
      n_scrolls++;
    end
  endfunction

  // Applies one item to the shadow and returns the result it must give
  function automatic tcw_result_t console_step(input logic [1:0] mode,
                                               input logic [7:0] ch,
                                               input logic [4:0] rr,
                                               input logic [6:0] rc);
    tcw_result_t r;
    int i;
    r = '0;
    case (mode)
      MODE_PUT: begin
        n_puts++;
        if (ch == NEWLINE_CODE) begin
          next_line();
        end else begin
          if (cur_col >= COLS) begin
            n_wraps++;
            next_line();
          end
          screen_shadow[cur_row * COLS + cur_col] = {bg_color, fg_color, ch};
          cur_col++;
        end
      end
      MODE_READ: begin
        n_reads++;
        if (rr < ROWS && rc < COLS) begin
          r.cell_char  = screen_shadow[rr * COLS + rc][7:0];
          r.cell_color = screen_shadow[rr * COLS + rc][15:8];
        end
      end
      MODE_CLEAR: begin
        n_clears++;
        for (i = 0; i < CELLS; i++) screen_shadow[i] = {bg_color, fg_color, BLANK_CODE};
      end
      default: ;
    endcase
    r.cursor_row = cur_row[4:0];
    r.cursor_col = cur_col[6:0];
    return r;
  endfunction

  task automatic drop_valid();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Sends one item in bursts with random gaps, returns the predicted result
  task automatic send_item(input logic [1:0] mode, input logic [7:0] ch,
                           input logic [4:0] rr, input logic [6:0] rc,
                           output tcw_result_t res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        drop_valid();
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, rc, rr, ch};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    n_items++;
    res = console_step(mode, ch, rr, rc);
  endtask

  task automatic issue(input logic [1:0] mode, input logic [7:0] ch,
                       input logic [4:0] rr, input logic [6:0] rc);
    tcw_result_t res;
    send_item(mode, ch, rr, rc, res);
    pending_results.push_back(res);
  endtask

  // Hold off until every result is back
  task automatic drain();
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Colors change only while the block is idle
  task automatic write_colors(input logic [3:0] f, input logic [3:0] b);
    drain();
    repeat (WALK_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= CFG_FG;
    cfg_data_i <= f;
    @(negedge clk_i);
    cfg_addr_i <= CFG_BG;
    cfg_data_i <= b;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    fg_color = f;
    bg_color = b;
    n_settings++;
  endtask

  // Reads mostly near the cursor, sometimes anywhere, sometimes out of range
  task automatic read_cell();
    int k;
    logic [4:0] rr;
    logic [6:0] rc;
    k = $urandom_range(99);
    if (k < 50) begin
      rr = cur_row[4:0];
      rc = 7'($urandom_range(0, (cur_col == 0) ? 0
                                  : ((cur_col > COLS) ? COLS : cur_col) - 1));
    end else if (k < 85) begin
      rr = 5'($urandom_range(0, ROWS - 1));
      rc = 7'($urandom_range(0, COLS - 1));
    end else begin
      rr = 5'($urandom_range(0, 31));
      rc = 7'($urandom_range(0, 127));
    end
    issue(MODE_READ, 8'($urandom_range(0, 255)), rr, rc);
  endtask

  // Random text: lines of varied length, some wrapping, with misc ops between
  task automatic type_text(input int count);
    int start, line_left, k;
    bit held;
    logic [7:0] ch;
    start = n_items;
    line_left = 0;
    held = 0;
    while (n_items - start < count) begin
      if (!held && n_items - start >= count / 2) begin
        drain();
        held = 1;
      end
      if (line_left > 0) begin
        if ($urandom_range(99) < 80) begin
          ch = 8'(($urandom_range(1) != 0) ? $urandom_range(32, 126)
                                            : $urandom_range(0, 255));
          if (ch == NEWLINE_CODE) ch = BLANK_CODE;
          issue(MODE_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
        end else begin
          read_cell();
        end
        line_left--;
        if (line_left == 0 && $urandom_range(99) < 85)
          issue(MODE_PUT, NEWLINE_CODE, 5'($urandom_range(0, 31)),
                7'($urandom_range(0, 127)));
      end else begin
        k = $urandom_range(99);
        if (k < 65) begin
          k = $urandom_range(99);
          if (k < 50) line_left = $urandom_range(1, 10);
          else if (k < 80) line_left = $urandom_range(11, 79);
          else line_left = $urandom_range(80, 170);
        end else if (k < 73) begin
          issue(MODE_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                7'($urandom_range(0, 127)));
        end else if (k < 83) begin
          issue(MODE_UNUSED, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                7'($urandom_range(0, 127)));
        end else begin
          read_cell();
        end
      end
    end
  endtask

  // Receiver: stalls at a rate picked at random among none, 30 and 70 percent
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) begin
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 70;
      endcase
    end
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void check_field(input string name, input int expv, input int got);
    if (expv != got) begin
      $error("%s: expected %0h, got %0h", name, expv, got);
      n_fail++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    tcw_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = tcw_result_t'(m_axis_tdata[$bits(tcw_result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $error("result item with no item pending: %h", m_axis_tdata);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        check_field("cell_char", int'(want.cell_char), int'(got.cell_char));
        check_field("cell_color", int'(want.cell_color), int'(got.cell_color));
        check_field("cursor_row", int'(want.cursor_row), int'(got.cursor_row));
        check_field("cursor_col", int'(want.cursor_col), int'(got.cursor_col));
        n_checked++;
      end
    end
  end

  // Watchdog on cycles without any accepted item or result
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    tcw_result_t res;
    int i;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_data_i = '0;
    stall_pct = 0;
    rx_cycle = 0;
    idle_cycles = 0;
    burst_left = 0;
    n_items = 0; n_puts = 0; n_reads = 0; n_clears = 0; n_scrolls = 0; n_wraps = 0;
    n_settings = 0; n_checked = 0; n_fail = 0;

    // shadow after reset: white-on-black spaces, cursor home
    for (i = 0; i < CELLS; i++) screen_shadow[i] = {RESET_COLOR, BLANK_CODE};
    cur_row = 0;
    cur_col = 0;
    fg_color = RESET_COLOR[3:0];
    bg_color = RESET_COLOR[7:4];

    directed_rows = '{
      '{MODE_READ,   8'h00, 5'd0,  7'd0,   1, BLANK_CODE, RESET_COLOR, 5'd0, 7'd0},
      '{MODE_READ,   8'hFF, 5'd24, 7'd79,  1, BLANK_CODE, RESET_COLOR, 5'd0, 7'd0},
      // reads out of range give zero
      '{MODE_READ,   8'h00, 5'd25, 7'd0,   1, 8'h00, 8'h00, 5'd0, 7'd0},
      '{MODE_READ,   8'h00, 5'd0,  7'd80,  1, 8'h00, 8'h00, 5'd0, 7'd0},
      '{MODE_READ,   8'hFF, 5'd31, 7'd127, 1, 8'h00, 8'h00, 5'd0, 7'd0},
      // unused mode only reports the cursor
      '{MODE_UNUSED, 8'hFF, 5'd31, 7'd127, 1, 8'h00, 8'h00, 5'd0, 7'd0},
      '{MODE_PUT,    8'h41, 5'd31, 7'd127, 1, 8'h00, 8'h00, 5'd0, 7'd1},
      '{MODE_PUT,    8'hFF, 5'd0,  7'd0,   0, 8'h00, 8'h00, 5'd0, 7'd0},
      '{MODE_PUT,    8'h00, 5'd0,  7'd0,   0, 8'h00, 8'h00, 5'd0, 7'd0},
      '{MODE_READ,   8'h00, 5'd0,  7'd0,   1, 8'h41, RESET_COLOR, 5'd0, 7'd3},
      '{MODE_READ,   8'h00, 5'd0,  7'd1,   0, 8'h00, 8'h00, 5'd0, 7'd0},
      '{MODE_READ,   8'h00, 5'd0,  7'd2,   0, 8'h00, 8'h00, 5'd0, 7'd0},
      // newline moves the cursor and writes no cell
      '{MODE_PUT,    NEWLINE_CODE, 5'd0, 7'd0, 1, 8'h00, 8'h00, 5'd1, 7'd0},
      '{MODE_READ,   8'h00, 5'd1,  7'd0,   1, BLANK_CODE, RESET_COLOR, 5'd1, 7'd0},
      // clear leaves the cursor in place
      '{MODE_CLEAR,  8'hFF, 5'd31, 7'd127, 1, 8'h00, 8'h00, 5'd1, 7'd0},
      '{MODE_READ,   8'h00, 5'd0,  7'd0,   0, 8'h00, 8'h00, 5'd0, 7'd0},
      '{MODE_PUT,    8'h7F, 5'd0,  7'd0,   0, 8'h00, 8'h00, 5'd0, 7'd0},
      '{MODE_UNUSED, 8'h00, 5'd0,  7'd0,   0, 8'h00, 8'h00, 5'd0, 7'd0},
      '{MODE_READ,   8'h00, 5'd1,  7'd0,   0, 8'h00, 8'h00, 5'd0, 7'd0}
    };

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset colors
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].mode, directed_rows[i].ch, directed_rows[i].rr,
                directed_rows[i].rc, res);
      if (directed_rows[i].typed) begin
        res.cell_char  = directed_rows[i].e_char;
        res.cell_color = directed_rows[i].e_color;
        res.cursor_row = directed_rows[i].e_row;
        res.cursor_col = directed_rows[i].e_col;
      end
      pending_results.push_back(res);
    end

    // random text under several color settings, extremes included
    write_colors(4'h0, 4'h0);
    type_text(PHASE_ITEMS);
    write_colors(4'hF, 4'hF);
    type_text(PHASE_ITEMS);
    write_colors(4'h0, 4'hF);
    type_text(PHASE_ITEMS);
    write_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    type_text(PHASE_ITEMS);
    write_colors(4'hF, 4'h0);
    type_text(PHASE_ITEMS);
    write_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    type_text(PHASE_ITEMS);

    drain();
    repeat (64) @(posedge clk_i);

    $display("Sent %0d items: %0d puts, %0d reads, %0d clears, %0d scrolls, %0d wraps",
             n_items, n_puts, n_reads, n_clears, n_scrolls, n_wraps);
    $display("%0d color settings, %0d results compared", n_settings, n_checked);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
